// ===== rtl/pwlbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the piecewise linear branch predictor.
// Depends on nothing; imported by the top level.
package pwlbp_pkg;

  localparam int ADDR_IN_W    = 32;
  localparam int THRESH_W     = 10;
  localparam int SUM_OUT_W    = 13;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd56;

  localparam int SUM_OUT_MAX = 4095;
  localparam int SUM_OUT_MIN = -4096;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  typedef logic signed [SUM_OUT_W-1:0] sum_out_t;

endpackage

// ===== rtl/piecewise_linear_branch_predictor.sv =====
`timescale 1ns / 1ps
// Piecewise linear branch predictor: weight memory, sequencer and history registers.
// Depends on pwlbp_pkg.
//
// Each transfer in is one predict or one update command and yields one transfer out. The
// weights sit in one synchronous memory with a write port and a read port, and one weight is
// read (or read, adjusted and written back) per cycle; an update that does not train reads no
// weights. A new command is taken only after the result of the last one has been issued.
// When ROWS or PATHS is not a power of two, the branch address is first reduced byte by byte
// for every command. After reset the block zeroes all ROWS*PATHS*(HISTORY+1) weight entries
// (17408 by default), one entry a cycle, and takes no input until that is done; the
// threshold register may be written throughout.
module piecewise_linear_branch_predictor #(
  parameter int ROWS        = 64,
  parameter int PATHS       = 16,
  parameter int HISTORY     = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pwlbp_pkg::THRESH_W-1:0]      cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: branch_address[31:0], predicted_dir, actual_taken, zero fill.
  input  logic [pwlbp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Fields: cmd.
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: predict_taken, weight_sum[12:0], trained, zero fill.
  output logic [pwlbp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import pwlbp_pkg::*;

  localparam int POSITIONS  = HISTORY + 1;
  localparam int ROW_STRIDE = PATHS * POSITIONS;
  localparam int DEPTH      = ROWS * ROW_STRIDE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PATH_W     = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int POS_W      = $clog2(POSITIONS);
  localparam int HIDX_W     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int MW         = ((ROW_W > PATH_W) ? ROW_W : PATH_W) + 1;
  localparam int SUM_W      = WEIGHT_BITS + $clog2(POSITIONS) + 1;
  localparam bit POW2       = ((ROWS & (ROWS - 1)) == 0) && ((PATHS & (PATHS - 1)) == 0);
  localparam int MOD_STEPS  = ADDR_IN_W / 8;

  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_BASE, ST_RUN, ST_LAST, ST_DONE
  } state_t;

  function automatic logic [MW-1:0] mod_byte(input logic [MW-1:0] r_in,
                                             input logic [7:0] b,
                                             input logic [MW-1:0] m);
    logic [MW:0]   t;
    logic [MW-1:0] r;
    r = r_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, b[i]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      r = t[MW-1:0];
    end
    return r;
  endfunction

  state_t                          state;
  logic [ADDR_W-1:0]               clr_addr;
  logic [THRESH_W-1:0]             train_threshold;
  logic                            cmd_q;
  logic                            taken_q;
  logic                            train_q;
  logic [ADDR_IN_W-1:0]            addr_sh;
  logic [1:0]                      mod_cnt;
  logic [MW-1:0]                   rem_row;
  logic [MW-1:0]                   rem_path;
  logic [ROW_W-1:0]                row;
  logic [PATH_W-1:0]               path;
  logic [ADDR_W-1:0]               row_base;
  logic [POS_W-1:0]                cnt;
  logic                            rd_v;
  logic [POS_W-1:0]                rd_pos;
  logic [ADDR_W-1:0]               rd_addr;
  logic signed [SUM_W-1:0]         acc;
  sum_out_t                        saved_sum;
  logic [PATH_W-1:0]               phist [HISTORY];
  logic                            ohist [HISTORY];
  logic                            out_valid;
  logic [OUT_TDATA_W-1:0]          out_data;

  logic signed [WEIGHT_BITS-1:0]   mem [DEPTH];
  logic signed [WEIGHT_BITS-1:0]   mem_q;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  logic signed [WEIGHT_BITS-1:0]   mem_wdata;
  logic                            mem_re;
  logic [ADDR_W-1:0]               mem_raddr;

  logic [POS_W-1:0]                cnt_m1;
  logic [POS_W-1:0]                rd_pos_m1;
  logic [PATH_W-1:0]               path_sel;
  logic                            rd_hist_o;
  logic signed [SUM_W-1:0]         w_ext;
  logic signed [SUM_W-1:0]         term;
  logic                            nudge_up;
  logic signed [WEIGHT_BITS-1:0]   nudged;
  logic signed [31:0]              acc_wide;
  sum_out_t                        sum_clamped;
  logic [SUM_OUT_W-1:0]            saved_mag;
  logic                            in_dir;
  logic                            in_taken;
  logic                            in_train;
  logic                            out_free;
  logic                            accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign out_free      = !out_valid || m_axis_tready;

  assign in_dir    = s_axis_tdata[ADDR_IN_W];
  assign in_taken  = s_axis_tdata[ADDR_IN_W+1];
  assign saved_mag = saved_sum[SUM_OUT_W-1] ? SUM_OUT_W'(-saved_sum) : SUM_OUT_W'(saved_sum);
  assign in_train  = (in_dir != in_taken) ||
                     ({{(SUM_OUT_W-THRESH_W){1'b0}}, train_threshold} > saved_mag);

  assign cnt_m1    = cnt - POS_W'(1);
  assign rd_pos_m1 = rd_pos - POS_W'(1);
  assign path_sel  = (cnt == '0) ? '0 : phist[cnt_m1[HIDX_W-1:0]];
  assign rd_hist_o = ohist[rd_pos_m1[HIDX_W-1:0]];

  assign mem_re    = (state == ST_RUN);
  assign mem_raddr = row_base + ADDR_W'(path_sel) * ADDR_W'(POSITIONS) + ADDR_W'(cnt);

  assign w_ext = SUM_W'(mem_q);
  assign term  = ((rd_pos == '0) || rd_hist_o) ? w_ext : -w_ext;

  assign nudge_up = (rd_pos == '0) ? taken_q : (rd_hist_o == taken_q);
  always_comb begin
    nudged = mem_q;
    if (nudge_up) begin
      if (mem_q != W_MAX) begin
        nudged = mem_q + WEIGHT_BITS'(1);
      end
    end else begin
      if (mem_q != W_MIN) begin
        nudged = mem_q - WEIGHT_BITS'(1);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = nudged;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (rd_v && (cmd_q == CMD_UPDATE)) begin
      mem_we = 1'b1;
    end
  end

  assign acc_wide = 32'(acc);
  always_comb begin
    if (acc_wide > SUM_OUT_MAX) begin
      sum_clamped = sum_out_t'(SUM_OUT_MAX);
    end else if (acc_wide < SUM_OUT_MIN) begin
      sum_clamped = sum_out_t'(SUM_OUT_MIN);
    end else begin
      sum_clamped = acc_wide[SUM_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      train_threshold <= THRESH_RESET;
      saved_sum       <= '0;
      rd_v            <= 1'b0;
      out_valid       <= 1'b0;
      for (int i = 0; i < HISTORY; i++) begin
        phist[i] <= '0;
        ohist[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        train_threshold <= cfg_wdata;
      end
      if (out_valid && m_axis_tready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      rd_v    <= mem_re;
      rd_pos  <= cnt;
      rd_addr <= mem_raddr;
      if (rd_v && (cmd_q == CMD_PREDICT)) begin
        acc <= acc + term;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q    <= s_axis_tuser;
            taken_q  <= in_taken;
            train_q  <= (s_axis_tuser == CMD_UPDATE) && in_train;
            addr_sh  <= s_axis_tdata[ADDR_IN_W-1:0];
            rem_row  <= '0;
            rem_path <= '0;
            mod_cnt  <= '0;
            row      <= ROW_W'(s_axis_tdata[ADDR_IN_W-1:0] & ADDR_IN_W'(ROWS - 1));
            path     <= PATH_W'(s_axis_tdata[ADDR_IN_W-1:0] & ADDR_IN_W'(PATHS - 1));
            state    <= POW2 ? ST_BASE : ST_MOD;
          end
        end
        ST_MOD: begin
          rem_row  <= mod_byte(rem_row, addr_sh[ADDR_IN_W-1 -: 8], MW'(ROWS));
          rem_path <= mod_byte(rem_path, addr_sh[ADDR_IN_W-1 -: 8], MW'(PATHS));
          addr_sh  <= addr_sh << 8;
          mod_cnt  <= mod_cnt + 2'd1;
          if (mod_cnt == 2'(MOD_STEPS - 1)) begin
            row   <= ROW_W'(mod_byte(rem_row, addr_sh[ADDR_IN_W-1 -: 8], MW'(ROWS)));
            path  <= PATH_W'(mod_byte(rem_path, addr_sh[ADDR_IN_W-1 -: 8], MW'(PATHS)));
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          row_base <= ADDR_W'(row) * ADDR_W'(ROW_STRIDE);
          acc      <= '0;
          cnt      <= '0;
          if ((cmd_q == CMD_PREDICT) || train_q) begin
            state <= ST_RUN;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_RUN: begin
          cnt <= cnt + POS_W'(1);
          if (cnt == POS_W'(HISTORY)) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (cmd_q == CMD_PREDICT) begin
              saved_sum <= sum_clamped;
              out_data  <= OUT_TDATA_W'({1'b0, sum_clamped, ~sum_clamped[SUM_OUT_W-1]});
            end else begin
              out_data <= OUT_TDATA_W'({train_q, {SUM_OUT_W{1'b0}}, 1'b0});
              for (int i = HISTORY - 1; i > 0; i--) begin
                phist[i] <= phist[i-1];
                ohist[i] <= ohist[i-1];
              end
              phist[0] <= path;
              ohist[0] <= taken_q;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("weight memory written while idle");

  a_predict_never_writes: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != ST_CLEAR)) |-> (cmd_q == CMD_UPDATE) && train_q)
    else $error("weight written by a command that does not train");

  a_read_data_in_window: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> ((state == ST_RUN) || (state == ST_LAST)))
    else $error("read data returned outside the weight pass");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[SUM_OUT_W+1]))
    else $error("result marks both a taken prediction and training");

endmodule
